// ----- sv/conv3x3_div_clamp_filter_macros.svh -----
// ----------------------------------------------------------------------------
// conv3x3_div_clamp_filter_macros
// Assertion macros shared by the filter modules.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_DIV_CLAMP_FILTER_MACROS_SVH
`define CONV3X3_DIV_CLAMP_FILTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define C3F_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define C3F_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/c3f_pkg.sv -----
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared constants and types of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3f_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SUM_W = 20;
    localparam int QUO_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KTOP  = 3'd0,
        REG_KMID  = 3'd1,
        REG_KBOT  = 3'd2,
        REG_DIV   = 3'd3,
        REG_WIDTH = 3'd4,
        REG_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } t_state;

    // Handshake between the top level and the divider.
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage

// ----- sv/conv3x3_div_clamp_filter.sv -----
// ----------------------------------------------------------------------------
// conv3x3_div_clamp_filter
// 3x3 convolution over a raster pixel stream, divide and clamp to 0..255.
// ----------------------------------------------------------------------------
// Flow: an accepted pixel is registered with the line store reads (ST_READ);
// an interior centre then runs the one-bit-a-cycle divider (ST_DIV) and the
// result is registered onto o_valid (ST_OUT); a border pixel gives no result.
// A new pixel is taken only in ST_IDLE, once the previous one is through.
// Reset (synchronous, active low) clears counters, window, state and o_valid and
// loads the default configuration; line store and data registers are not cleared.
`include "conv3x3_div_clamp_filter_macros.svh"
module conv3x3_div_clamp_filter import c3f_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_pixel,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_filtered_value,
    output logic [9:0]            o_centre_row,
    output logic [9:0]            o_centre_col,
    output logic                  o_frame_last
);
    logic [23:0]       r_ktop, r_kmid, r_kbot;
    logic [7:0]        r_divisor;
    logic [SIZE_W-1:0] r_width, r_height;
    logic [SIZE_W-1:0] eff_w, eff_h;

    t_state r_state, n_state;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [7:0]       r_px;
    logic [7:0]       r_win [3][2];
    logic [7:0]       rd0, rd1;
    logic             accept, do_read;
    logic             interior, last_pos;
    logic signed [SUM_W-1:0] sum;
    logic             r_interior;
    logic [9:0]       r_orow, r_ocol;
    logic             r_olast;
    logic [7:0]       r_oval;
    logic [9:0]       r_res_row, r_res_col;
    logic             r_res_last;
    logic             r_ovalid;
    logic [7:0]       quot;
    t_div_ctl         dctl;

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktop <= 24'd0;
            r_kmid <= 24'd256;
            r_kbot <= 24'd0;
            r_divisor <= 8'd1;
            r_width <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KTOP:   r_ktop <= i_cfg_data;
                REG_KMID:   r_kmid <= i_cfg_data;
                REG_KBOT:   r_kbot <= i_cfg_data;
                REG_DIV:    r_divisor <= i_cfg_data[7:0];
                REG_WIDTH:  r_width <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_w = (r_width < SIZE_W'(3)) ? SIZE_W'(3) :
                   (r_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : r_width;
    assign eff_h = (r_height < SIZE_W'(3)) ? SIZE_W'(3) :
                   (r_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_height;

    // Position of the accepted pixel, after frame start and shrink wraps.
    always_comb begin
        logic [SIZE_W:0] c, r;
        c = i_frame_start ? '0 : {2'b00, r_col};
        r = i_frame_start ? '0 : {2'b00, r_row};
        if (c >= {1'b0, eff_w}) begin
            c = '0;
            r = r + 1'b1;
        end
        if (r >= {1'b0, eff_h}) begin
            r = '0;
        end
        cur_col = c[COL_W-1:0];
        cur_row = r[ROW_W-1:0];
    end

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign do_read = (r_state == ST_READ);

    // Two line stores: the older row and the newer row, same column address.
    c3f_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
        .i_clk(i_clk), .i_we(do_read), .i_waddr(r_col), .i_wdata(rd1),
        .i_raddr(cur_col), .o_rdata(rd0));
    c3f_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
        .i_clk(i_clk), .i_we(do_read), .i_waddr(r_col), .i_wdata(r_px),
        .i_raddr(cur_col), .o_rdata(rd1));

    function automatic logic signed [SUM_W-1:0] tap(input logic [23:0] k,
                                                    input int pos,
                                                    input logic [7:0] p);
        logic signed [7:0] cf;
        cf = k[8*pos +: 8];
        return SUM_W'(cf * $signed({1'b0, p}));
    endfunction

    assign sum = tap(r_ktop, 0, r_win[0][0]) + tap(r_ktop, 1, r_win[0][1]) +
                 tap(r_ktop, 2, rd0) +
                 tap(r_kmid, 0, r_win[1][0]) + tap(r_kmid, 1, r_win[1][1]) +
                 tap(r_kmid, 2, rd1) +
                 tap(r_kbot, 0, r_win[2][0]) + tap(r_kbot, 1, r_win[2][1]) +
                 tap(r_kbot, 2, r_px);

    assign interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign last_pos = ({1'b0, r_row} == eff_h - 1'b1) &&
                      ({1'b0, r_col} == eff_w - 1'b1);

    assign dctl.start = do_read && interior;

    c3f_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dctl.start), .i_sum(sum),
        .i_divisor(r_divisor), .o_done(dctl.done), .o_quot(quot));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_READ;
            ST_READ: n_state = interior ? ST_DIV : ST_IDLE;
            ST_DIV:  if (dctl.done) n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_ovalid <= 1'b0;
            r_interior <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= '0;
                r_win[k][1] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col <= cur_col;
                r_row <= cur_row;
                r_px  <= i_pixel;
            end
            if (do_read) begin
                r_interior <= interior;
                r_orow <= 10'(r_row - 1'b1);
                r_ocol <= 10'(r_col - 1'b1);
                r_olast <= last_pos;
                r_win[0][0] <= r_win[0][1]; r_win[0][1] <= rd0;
                r_win[1][0] <= r_win[1][1]; r_win[1][1] <= rd1;
                r_win[2][0] <= r_win[2][1]; r_win[2][1] <= r_px;
                // Advance to the next raster position.
                if ({1'b0, r_col} + 1'b1 >= eff_w) begin
                    r_col <= '0;
                    r_row <= ({1'b0, r_row} + 1'b1 >= eff_h) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
                r_oval <= quot;
                r_res_row <= r_orow;
                r_res_col <= r_ocol;
                r_res_last <= r_olast;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_filtered_value = r_oval;
    assign o_centre_row = r_res_row;
    assign o_centre_col = r_res_col;
    assign o_frame_last = r_res_last;

    `C3F_ASSERT(a_ready_only_idle, i_clk, i_rst_n,
        o_ready |-> (r_state == ST_IDLE), "ready outside idle")
    `C3F_ASSERT(a_div_from_interior, i_clk, i_rst_n,
        (r_state == ST_DIV) |-> r_interior, "division for a border pixel")
    `C3F_ASSERT(a_start_after_accept, i_clk, i_rst_n,
        dctl.start |-> $past(accept), "division started without a transfer")
    `C3F_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == ST_IDLE && !o_valid), "not idle after reset")
endmodule

// ----- sv/c3f_ram.sv -----
// ----------------------------------------------------------------------------
// c3f_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/c3f_div.sv -----
// ----------------------------------------------------------------------------
// c3f_div
// Restoring divider: signed sum by unsigned 8-bit divisor, one bit a cycle,
// quotient truncated toward zero and clamped to 0..255.
// ----------------------------------------------------------------------------
`include "conv3x3_div_clamp_filter_macros.svh"
module c3f_div import c3f_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [7:0]              i_divisor,
    output logic                    o_done,
    output logic [7:0]              o_quot
);
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [QUO_W-1:0] r_num, n_num;
    logic [8:0]       r_rem, n_rem;
    logic [7:0]       r_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_neg;
    logic             r_done, n_done;
    logic [9:0]       trial;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_num[QUO_W-1]} - {2'b00, r_div};
        if (r_busy) begin
            if (!trial[9]) begin
                n_rem = trial[8:0];
                n_num = {r_num[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[7:0], r_num[QUO_W-1]};
                n_num = {r_num[QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUO_W);
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        if (i_start) begin
            // A negative sum always clamps to zero, so the sum bits are divided as
            // they stand and the sign bit only forces the result to zero.
            r_neg <= i_sum[SUM_W-1];
            r_num <= i_sum;
            r_rem <= '0;
            r_div <= (i_divisor == 8'd0) ? 8'd1 : i_divisor;
        end else begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? 8'd0 :
                    (r_num[QUO_W-1:8] != '0) ? 8'd255 : r_num[7:0];

    `C3F_ASSERT(a_div_no_overlap, i_clk, i_rst_n, r_busy |-> !i_start,
        "divider restarted while busy")
    `C3F_ASSERT(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy),
        "divider done without a running division")
    `C3F_ASSERT(a_div_done_pulse, i_clk, i_rst_n, r_done |=> !r_done,
        "divider done held for two cycles")
endmodule
